[rtl/hpp_pkg.sv]
// ----------------------------------------------------------------------------
// hpp_pkg
// Shared widths, register codes, reset values and pipeline bus types for the
// homography point projection block.
// ----------------------------------------------------------------------------
package hpp_pkg;

    // field widths
    localparam int COORD_W  = 24;
    localparam int WGT_W    = 16;
    localparam int COEF_W   = 32;
    localparam int LIN_W    = 64;
    localparam int SUM_W    = 64;
    // quotient bits: 25 integer magnitude bits plus one rounding bit
    localparam int QB       = 26;
    localparam int RW       = SUM_W + QB;
    localparam int FRAC_DEF = 8;

    // configuration register codes
    typedef enum logic [2:0] {
        REG_ROW0_LIN = 3'd0,
        REG_ROW0_OFF = 3'd1,
        REG_ROW1_LIN = 3'd2,
        REG_ROW1_OFF = 3'd3,
        REG_ROW2_LIN = 3'd4,
        REG_ROW2_OFF = 3'd5
    } reg_idx_t;

    localparam logic [LIN_W-1:0]  ROW0_LIN_RST = 64'h0000_0000_0010_0000;
    localparam logic [COEF_W-1:0] ROW0_OFF_RST = 32'h0000_0000;
    localparam logic [LIN_W-1:0]  ROW1_LIN_RST = 64'h0010_0000_0000_0000;
    localparam logic [COEF_W-1:0] ROW1_OFF_RST = 32'h0000_0000;
    localparam logic [LIN_W-1:0]  ROW2_LIN_RST = 64'h0000_0000_0000_0000;
    localparam logic [COEF_W-1:0] ROW2_OFF_RST = 32'h0100_0000;

    // output magnitude limits
    localparam logic [QB-1:0] MAG_MAX_POS = 26'd8388607;
    localparam logic [QB-1:0] MAG_MAX_NEG = 26'd8388608;

    // matrix coefficients
    typedef struct packed {
        logic signed [COEF_W-1:0] h00;
        logic signed [COEF_W-1:0] h01;
        logic signed [COEF_W-1:0] h02;
        logic signed [COEF_W-1:0] h10;
        logic signed [COEF_W-1:0] h11;
        logic signed [COEF_W-1:0] h12;
        logic signed [COEF_W-1:0] h20;
        logic signed [COEF_W-1:0] h21;
        logic signed [COEF_W-1:0] h22;
    } coef_t;

    // divider pipeline payload
    typedef struct packed {
        logic [RW-1:0]    u_rem;
        logic [RW-1:0]    v_rem;
        logic [SUM_W-1:0] den;
        logic [QB-1:0]    u_q;
        logic [QB-1:0]    v_q;
        logic             u_neg;
        logic             v_neg;
        logic             u_big;
        logic             v_big;
        logic             s_zero;
    } div_bus_t;

    // result payload
    typedef struct packed {
        logic [COORD_W-1:0] x_out;
        logic [COORD_W-1:0] y_out;
        logic               defined;
        logic               saturated;
    } res_t;

endpackage

[rtl/hpp_point_if.sv]
// ----------------------------------------------------------------------------
// hpp_point_if
// Valid/ready channel carrying one homogeneous input point.
// ----------------------------------------------------------------------------
interface hpp_point_if;
    logic               valid;
    logic               ready;
    logic signed [23:0] x_coord;
    logic signed [23:0] y_coord;
    logic signed [15:0] w_coord;

    modport source (output valid, output x_coord, output y_coord, output w_coord,
                    input ready);
    modport sink   (input valid, input x_coord, input y_coord, input w_coord,
                    output ready);
endinterface

[rtl/hpp_proj_if.sv]
// ----------------------------------------------------------------------------
// hpp_proj_if
// Valid/ready channel carrying one projected point.
// ----------------------------------------------------------------------------
interface hpp_proj_if;
    logic               valid;
    logic               ready;
    logic signed [23:0] x_out;
    logic signed [23:0] y_out;
    logic               defined;
    logic               saturated;

    modport source (output valid, output x_out, output y_out, output defined,
                    output saturated, input ready);
    modport sink   (input valid, input x_out, input y_out, input defined,
                    input saturated, output ready);
endinterface

[rtl/homography_point_projection.sv]
// ----------------------------------------------------------------------------
// homography_point_projection
// Projects a homogeneous point through a configured 3x3 homography and
// returns (u/s, v/s) in fixed point, with defined and saturated flags.
//
//   channel   direction   contents
//   point     in          x_coord, y_coord, w_coord
//   proj      out         x_out, y_out, defined, saturated
//   cfg       in          cfg_we, cfg_addr, cfg_wdata (write only)
//
// Takes one item per clock unless stalled by proj.ready. Pipeline: four front
// stages (products, sums, magnitudes, setup), 26 divider stages (one quotient
// bit each, u and v side by side) and one output stage.
// Reset clears all valid bits and loads the identity matrix.
// Every stage holds when its successor is full and stalled; empty stages
// still fill, so the input keeps taking items until the pipe is full.
// ----------------------------------------------------------------------------
module homography_point_projection
    import hpp_pkg::*;
#(
    parameter int COORD_FRAC_BITS = FRAC_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [2:0]        cfg_addr,
    input  logic [LIN_W-1:0]  cfg_wdata,
    hpp_point_if.sink         point,
    hpp_proj_if.source        proj
);

    logic [LIN_W-1:0]  row0_lin_reg, row1_lin_reg, row2_lin_reg;
    logic [COEF_W-1:0] row0_off_reg, row1_off_reg, row2_off_reg;
    coef_t             coef;

    logic     pv   [QB+1];
    logic     pr   [QB+1];
    div_bus_t pbus [QB+1];
    res_t     res;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row0_lin_reg <= ROW0_LIN_RST;
            row0_off_reg <= ROW0_OFF_RST;
            row1_lin_reg <= ROW1_LIN_RST;
            row1_off_reg <= ROW1_OFF_RST;
            row2_lin_reg <= ROW2_LIN_RST;
            row2_off_reg <= ROW2_OFF_RST;
        end
        else if (cfg_we)
        begin
            case (reg_idx_t'(cfg_addr))
                REG_ROW0_LIN: row0_lin_reg <= cfg_wdata;
                REG_ROW0_OFF: row0_off_reg <= cfg_wdata[COEF_W-1:0];
                REG_ROW1_LIN: row1_lin_reg <= cfg_wdata;
                REG_ROW1_OFF: row1_off_reg <= cfg_wdata[COEF_W-1:0];
                REG_ROW2_LIN: row2_lin_reg <= cfg_wdata;
                REG_ROW2_OFF: row2_off_reg <= cfg_wdata[COEF_W-1:0];
                default: ;
            endcase
        end
    end

    // unpack coefficients
    always_comb
    begin
        coef.h00 = row0_lin_reg[COEF_W-1:0];
        coef.h01 = row0_lin_reg[LIN_W-1:COEF_W];
        coef.h02 = row0_off_reg;
        coef.h10 = row1_lin_reg[COEF_W-1:0];
        coef.h11 = row1_lin_reg[LIN_W-1:COEF_W];
        coef.h12 = row1_off_reg;
        coef.h20 = row2_lin_reg[COEF_W-1:0];
        coef.h21 = row2_lin_reg[LIN_W-1:COEF_W];
        coef.h22 = row2_off_reg;
    end

    // front end
    hpp_front #(.FRAC(COORD_FRAC_BITS)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .coef      (coef),
        .in_valid  (point.valid),
        .in_ready  (point.ready),
        .x_coord   (point.x_coord),
        .y_coord   (point.y_coord),
        .w_coord   (point.w_coord),
        .out_valid (pv[0]),
        .out_ready (pr[0]),
        .out_bus   (pbus[0])
    );

    // divider, most significant quotient bit first
    for (genvar g = 0; g < QB; g++)
    begin : g_div
        hpp_div_step #(.J(QB - 1 - g)) u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (pv[g]),
            .in_ready  (pr[g]),
            .in_bus    (pbus[g]),
            .out_valid (pv[g+1]),
            .out_ready (pr[g+1]),
            .out_bus   (pbus[g+1])
        );
    end

    // output stage
    hpp_back #(.FRAC(COORD_FRAC_BITS)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pv[QB]),
        .in_ready  (pr[QB]),
        .in_bus    (pbus[QB]),
        .out_valid (proj.valid),
        .out_ready (proj.ready),
        .out_res   (res)
    );

    assign proj.x_out     = res.x_out;
    assign proj.y_out     = res.y_out;
    assign proj.defined   = res.defined;
    assign proj.saturated = res.saturated;

endmodule

[rtl/hpp_front.sv]
// ----------------------------------------------------------------------------
// hpp_front
// Matrix product front end: products, row sums, magnitudes, then overflow
// check and divider setup. Four register stages with bubble collapsing.
// ----------------------------------------------------------------------------
module hpp_front
    import hpp_pkg::*;
#(
    parameter int FRAC = FRAC_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  coef_t                     coef,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic signed [COORD_W-1:0] x_coord,
    input  logic signed [COORD_W-1:0] y_coord,
    input  logic signed [WGT_W-1:0]   w_coord,
    output logic                      out_valid,
    input  logic                      out_ready,
    output div_bus_t                  out_bus
);

    localparam int K      = 8 + FRAC;
    localparam int BIG_SH = QB - 1 - K;
    localparam int REM_SH = K + 1;
    localparam int PL_W   = COEF_W + COORD_W;
    localparam int PO_W   = COEF_W + WGT_W;

    logic [3:0] v_reg;
    logic [3:0] rdy;

    // stage 1 products
    logic signed [PL_W-1:0] p00_reg, p01_reg, p10_reg, p11_reg, p20_reg, p21_reg;
    logic signed [PO_W-1:0] p02_reg, p12_reg, p22_reg;
    // stage 2 sums
    logic signed [SUM_W-1:0] u_reg, v_reg_s, s_reg;
    logic signed [SUM_W-1:0] u_next, v_next, s_next;
    // stage 3 magnitudes
    logic [SUM_W-1:0] um_reg, vm_reg, sm_reg;
    logic             un_reg, vn_reg, sz_reg;
    logic [SUM_W-1:0] um_next, vm_next, sm_next;
    // stage 4 divider setup
    div_bus_t bus_reg, bus_next;

    // ready chain, a stage moves when empty or when its successor moves
    always_comb
    begin
        rdy[3] = !v_reg[3] || out_ready;
        rdy[2] = !v_reg[2] || rdy[3];
        rdy[1] = !v_reg[1] || rdy[2];
        rdy[0] = !v_reg[0] || rdy[1];
    end

    assign in_ready  = rdy[0];
    assign out_valid = v_reg[3];
    assign out_bus   = bus_reg;

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (rdy[0]) v_reg[0] <= in_valid;
            if (rdy[1]) v_reg[1] <= v_reg[0];
            if (rdy[2]) v_reg[2] <= v_reg[1];
            if (rdy[3]) v_reg[3] <= v_reg[2];
        end
    end

    // row sums aligned to common fraction points
    always_comb
    begin
        u_next = (SUM_W'(p00_reg) <<< 4) + (SUM_W'(p01_reg) <<< 4)
               + (SUM_W'(p02_reg) <<< FRAC);
        v_next = (SUM_W'(p10_reg) <<< 4) + (SUM_W'(p11_reg) <<< 4)
               + (SUM_W'(p12_reg) <<< FRAC);
        s_next = (SUM_W'(p20_reg) <<< 2) + (SUM_W'(p21_reg) <<< 2)
               + (SUM_W'(p22_reg) <<< FRAC);
    end

    // magnitudes
    always_comb
    begin
        um_next = u_reg[SUM_W-1] ? (~u_reg + 1'b1) : u_reg;
        vm_next = v_reg_s[SUM_W-1] ? (~v_reg_s + 1'b1) : v_reg_s;
        sm_next = s_reg[SUM_W-1] ? (~s_reg + 1'b1) : s_reg;
    end

    // overflow check and initial remainders
    always_comb
    begin
        bus_next        = '0;
        bus_next.den    = sm_reg;
        bus_next.u_big  = {{QB{1'b0}}, um_reg} >= ({{QB{1'b0}}, sm_reg} << BIG_SH);
        bus_next.v_big  = {{QB{1'b0}}, vm_reg} >= ({{QB{1'b0}}, sm_reg} << BIG_SH);
        bus_next.u_rem  = {{QB{1'b0}}, um_reg} << REM_SH;
        bus_next.v_rem  = {{QB{1'b0}}, vm_reg} << REM_SH;
        bus_next.u_neg  = un_reg;
        bus_next.v_neg  = vn_reg;
        bus_next.s_zero = sz_reg;
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (rdy[0] && in_valid)
        begin
            p00_reg <= coef.h00 * x_coord;
            p01_reg <= coef.h01 * y_coord;
            p02_reg <= coef.h02 * w_coord;
            p10_reg <= coef.h10 * x_coord;
            p11_reg <= coef.h11 * y_coord;
            p12_reg <= coef.h12 * w_coord;
            p20_reg <= coef.h20 * x_coord;
            p21_reg <= coef.h21 * y_coord;
            p22_reg <= coef.h22 * w_coord;
        end
        if (rdy[1] && v_reg[0])
        begin
            u_reg   <= u_next;
            v_reg_s <= v_next;
            s_reg   <= s_next;
        end
        if (rdy[2] && v_reg[1])
        begin
            um_reg <= um_next;
            vm_reg <= vm_next;
            sm_reg <= sm_next;
            un_reg <= u_reg[SUM_W-1] ^ s_reg[SUM_W-1];
            vn_reg <= v_reg_s[SUM_W-1] ^ s_reg[SUM_W-1];
            sz_reg <= (s_reg == '0);
        end
        if (rdy[3] && v_reg[2])
        begin
            bus_reg <= bus_next;
        end
    end

endmodule

[rtl/hpp_div_step.sv]
// ----------------------------------------------------------------------------
// hpp_div_step
// One restoring division stage: decides quotient bit J for both u and v
// against the shared denominator.
// ----------------------------------------------------------------------------
module hpp_div_step
    import hpp_pkg::*;
#(
    parameter int J = 0
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  div_bus_t in_bus,
    output logic     out_valid,
    input  logic     out_ready,
    output div_bus_t out_bus
);

    logic     v_reg;
    div_bus_t bus_reg, bus_next;
    logic [RW-1:0] dsh;

    assign in_ready  = !v_reg || out_ready;
    assign out_valid = v_reg;
    assign out_bus   = bus_reg;

    // compare and subtract the shifted denominator
    always_comb
    begin
        dsh      = {{QB{1'b0}}, in_bus.den} << J;
        bus_next = in_bus;
        if (in_bus.u_rem >= dsh)
        begin
            bus_next.u_rem  = in_bus.u_rem - dsh;
            bus_next.u_q[J] = 1'b1;
        end
        if (in_bus.v_rem >= dsh)
        begin
            bus_next.v_rem  = in_bus.v_rem - dsh;
            bus_next.v_q[J] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            bus_reg <= bus_next;
        end
    end

endmodule

[rtl/hpp_back.sv]
// ----------------------------------------------------------------------------
// hpp_back
// Output stage: rounds the quotients, clamps to range, applies sign and
// substitutes the undefined result for a zero denominator.
// ----------------------------------------------------------------------------
module hpp_back
    import hpp_pkg::*;
#(
    parameter int FRAC = FRAC_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  div_bus_t in_bus,
    output logic     out_valid,
    input  logic     out_ready,
    output res_t     out_res
);

    localparam logic [COORD_W-1:0] UNDEF_VAL = COORD_W'(-(1 << FRAC));

    logic       v_reg;
    res_t       res_reg, res_next;
    logic [QB:0]   u_sum, v_sum;
    logic [QB-1:0] u_mag, v_mag;
    logic          u_sat, v_sat;

    assign in_ready  = !v_reg || out_ready;
    assign out_valid = v_reg;
    assign out_res   = res_reg;

    // round half away from zero, clamp, sign
    always_comb
    begin
        u_sum = {1'b0, in_bus.u_q} + 1'b1;
        v_sum = {1'b0, in_bus.v_q} + 1'b1;
        u_mag = u_sum[QB:1];
        v_mag = v_sum[QB:1];
        u_sat = in_bus.u_big
              || (in_bus.u_neg ? (u_mag > MAG_MAX_NEG) : (u_mag > MAG_MAX_POS));
        v_sat = in_bus.v_big
              || (in_bus.v_neg ? (v_mag > MAG_MAX_NEG) : (v_mag > MAG_MAX_POS));
        if (u_sat) u_mag = in_bus.u_neg ? MAG_MAX_NEG : MAG_MAX_POS;
        if (v_sat) v_mag = in_bus.v_neg ? MAG_MAX_NEG : MAG_MAX_POS;
        res_next.x_out     = in_bus.u_neg ? COORD_W'(~u_mag + 1'b1) : COORD_W'(u_mag);
        res_next.y_out     = in_bus.v_neg ? COORD_W'(~v_mag + 1'b1) : COORD_W'(v_mag);
        res_next.defined   = 1'b1;
        res_next.saturated = u_sat || v_sat;
        if (in_bus.s_zero)
        begin
            res_next.x_out     = UNDEF_VAL;
            res_next.y_out     = UNDEF_VAL;
            res_next.defined   = 1'b0;
            res_next.saturated = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            res_reg <= res_next;
        end
    end

endmodule

[rtl/hpp_check.sv]
// ----------------------------------------------------------------------------
// hpp_check
// Port-level checks for the homography point projection block, bound to
// the top level.
// ----------------------------------------------------------------------------
module hpp_check (
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [23:0] x_out,
    input logic [23:0] y_out,
    input logic        defined,
    input logic        saturated
);

    // a result waiting to be taken stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result withdrawn before taken");

    // a stalled result keeps its value
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(x_out) && $stable(y_out))
        else $error("stalled result changed");

    // an empty output stage means the whole pipe can take an item
    a_ready_when_empty: assert property (@(posedge clk)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output stage");

    // undefined results carry equal x and y values and no saturation
    a_undef_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !defined |-> !saturated && (x_out == y_out))
        else $error("malformed undefined result");

    // nothing offered once reset has been seen at an edge
    a_reset_idle: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("result offered in reset");

endmodule

bind homography_point_projection hpp_check u_hpp_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (point.ready),
    .out_valid (proj.valid),
    .out_ready (proj.ready),
    .x_out     (proj.x_out),
    .y_out     (proj.y_out),
    .defined   (proj.defined),
    .saturated (proj.saturated)
);

[tb/sv/homography_point_projection_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// homography_point_projection_tb
// Self-checking bench for the homography point projection block. Points go in
// over a valid/ready channel, each projected result is checked field by field
// against an in-bench fixed-point predictor. Matrices are reloaded between
// phases: reset identity, all-max and all-min coefficients, realistic
// perspective matrices and fully random ones.
// ----------------------------------------------------------------------------
module homography_point_projection_tb;
    import hpp_pkg::*;

    localparam int FRAC = 8;
    localparam longint unsigned QUOT_CAP = 64'd33554432;

    typedef struct {
        logic signed [23:0] x_out;
        logic signed [23:0] y_out;
        logic               defined;
        logic               saturated;
    } proj_exp_t;

    typedef struct {
        logic signed [23:0] x;
        logic signed [23:0] y;
        logic signed [15:0] w;
        bit                 typed;
        proj_exp_t          res;
    } dir_row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_addr;
    logic [63:0] cfg_wdata;

    hpp_point_if point ();
    hpp_proj_if  proj ();

    // predictor copy of the matrix: h00 h01 h02 h10 h11 h12 h20 h21 h22
    logic signed [31:0] coef [9];
    proj_exp_t          proj_q [$];
    int                 errors;
    bit                 quiet;
    bit                 hold_req;
    dir_row_t           dir_tab [12];

    homography_point_projection u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .point     (point.sink),
        .proj      (proj.source)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // rounded scaled quotient, clamped to the output range
    function automatic logic signed [23:0] div_round(longint num, longint den,
                                                     inout bit sat);
        longint unsigned n, d, q, r, r2;
        bit neg, big;
        int i;
        neg = (num < 0) != (den < 0);
        n = (num < 0) ? 64'd0 - num : num;
        d = (den < 0) ? 64'd0 - den : den;
        q = n / d;
        r = n % d;
        big = q >= QUOT_CAP;
        for (i = 0; i < 8 + FRAC && !big; i++)
        begin
            r2 = r << 1;
            q = q << 1;
            if (r2 >= d)
            begin
                q = q | 64'd1;
                r2 = r2 - d;
            end
            r = r2;
            if (q >= QUOT_CAP)
                big = 1'b1;
        end
        if (!big && (r << 1) >= d)
            q++;
        if (neg)
        begin
            if (big || q > 64'd8388608)
            begin
                q = 64'd8388608;
                sat = 1'b1;
            end
            return 24'(64'd0 - q);
        end
        if (big || q > 64'd8388607)
        begin
            q = 64'd8388607;
            sat = 1'b1;
        end
        return 24'(q);
    endfunction

    // projected point for the current matrix
    function automatic proj_exp_t project_point(logic signed [23:0] x,
                                                logic signed [23:0] y,
                                                logic signed [15:0] w);
        proj_exp_t e;
        longint u, v, s;
        bit sat;
        u = (longint'(coef[0]) * x + longint'(coef[1]) * y) * 16
            + longint'(coef[2]) * w * (1 << FRAC);
        v = (longint'(coef[3]) * x + longint'(coef[4]) * y) * 16
            + longint'(coef[5]) * w * (1 << FRAC);
        s = (longint'(coef[6]) * x + longint'(coef[7]) * y) * 4
            + longint'(coef[8]) * w * (1 << FRAC);
        sat = 1'b0;
        if (s == 0)
        begin
            e.x_out = -(24'sd1 <<< FRAC);
            e.y_out = -(24'sd1 <<< FRAC);
            e.defined = 1'b0;
            e.saturated = 1'b0;
            return e;
        end
        e.x_out = div_round(u, s, sat);
        e.y_out = div_round(v, s, sat);
        e.defined = 1'b1;
        e.saturated = sat;
        return e;
    endfunction

    // register write, block idle
    task automatic write_reg(logic [2:0] idx, logic [63:0] data);
        cfg_we = 1'b1;
        cfg_addr = idx;
        cfg_wdata = data;
        @(posedge clk);
        if (idx <= REG_ROW2_OFF)
        begin
            if (idx[0] == 1'b0)
            begin
                coef[idx[2:1] * 3] = data[31:0];
                coef[idx[2:1] * 3 + 1] = data[63:32];
            end
            else
                coef[idx[2:1] * 3 + 2] = data[31:0];
        end
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // offer one item until accepted; entered and left just after a falling edge
    task automatic send_point(logic signed [23:0] x, logic signed [23:0] y,
                              logic signed [15:0] w, bit typed, proj_exp_t res);
        while (!quiet && $urandom_range(0, 99) < 7)
        begin
            point.valid = 1'b0;
            @(negedge clk);
        end
        point.valid = 1'b1;
        point.x_coord = x;
        point.y_coord = y;
        point.w_coord = w;
        do
            @(posedge clk);
        while (!point.ready);
        proj_q.push_back(typed ? res : project_point(x, y, w));
        @(negedge clk);
    endtask

    // drain: wait until every expected item has come back
    task automatic drain();
        point.valid = 1'b0;
        while (proj_q.size() != 0)
            @(negedge clk);
    endtask

    function automatic logic signed [31:0] rand_signed(int span);
        return $signed($urandom_range(0, 2 * span)) - span;
    endfunction

    // load a new matrix; kind picks extremes, realistic or random values
    task automatic load_matrix(int kind);
        logic [31:0] h [9];
        int i;
        for (i = 0; i < 9; i++)
        begin
            case (kind)
                0: h[i] = 32'h7fff_ffff;
                1: h[i] = 32'h8000_0000;
                2: h[i] = $urandom;
                default:
                begin
                    case (i)
                        0, 4:    h[i] = rand_signed(4 << 20);
                        1, 3:    h[i] = rand_signed(1 << 20);
                        2, 5:    h[i] = rand_signed(1000 << 16);
                        6, 7:    h[i] = rand_signed(1 << 20);
                        default: h[i] = (1 << 24) + rand_signed(1 << 23);
                    endcase
                end
            endcase
        end
        // sometimes a purely affine matrix so that w = 0 gives no denominator
        if (kind == 3 && $urandom_range(0, 3) == 0)
        begin
            h[6] = '0;
            h[7] = '0;
        end
        write_reg(REG_ROW0_LIN, {h[1], h[0]});
        write_reg(REG_ROW0_OFF, {32'($urandom), h[2]});
        write_reg(REG_ROW1_LIN, {h[4], h[3]});
        write_reg(REG_ROW1_OFF, {32'($urandom), h[5]});
        write_reg(REG_ROW2_LIN, {h[7], h[6]});
        write_reg(REG_ROW2_OFF, {32'($urandom), h[8]});
        // unused indexes must not disturb the matrix
        write_reg(3'(6 + $urandom_range(0, 1)), {$urandom, $urandom});
    endtask

    function automatic logic signed [23:0] rand_coord(bit wide);
        if (wide)
            return 24'($urandom);
        return 24'($signed($urandom_range(0, 2560 << 8)) - (512 << 8));
    endfunction

    // result receiver: random stalls plus one long hold-off on request
    initial
    begin
        proj.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                proj.ready = 1'b0;
                repeat (300) @(negedge clk);
                hold_req = 1'b0;
            end
            else
                proj.ready = quiet || ($urandom_range(0, 99) >= 7);
        end
    end

    // result checker
    always @(posedge clk)
    begin
        proj_exp_t e;
        if (rst_n && proj.valid && proj.ready)
        begin
            if (proj_q.size() == 0)
            begin
                $error("unexpected item x_out %0d y_out %0d",
                       proj.x_out, proj.y_out);
                errors++;
            end
            else
            begin
                e = proj_q.pop_front();
                if (proj.x_out !== e.x_out)
                begin
                    $error("x_out expected %0d actual %0d", e.x_out, proj.x_out);
                    errors++;
                end
                if (proj.y_out !== e.y_out)
                begin
                    $error("y_out expected %0d actual %0d", e.y_out, proj.y_out);
                    errors++;
                end
                if (proj.defined !== e.defined)
                begin
                    $error("defined expected %0d actual %0d", e.defined, proj.defined);
                    errors++;
                end
                if (proj.saturated !== e.saturated)
                begin
                    $error("saturated expected %0d actual %0d",
                           e.saturated, proj.saturated);
                    errors++;
                end
            end
        end
    end

    // run limit
    initial
    begin
        #400000;
        $display("DONE: errors detected");
        $finish;
    end

    // stimulus
    initial
    begin
        int ph, i, kind;
        bit wide;
        logic signed [15:0] w;
        proj_exp_t none;
        errors = 0;
        quiet = 1'b0;
        hold_req = 1'b0;
        none = '{0, 0, 0, 0};
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = '0;
        cfg_wdata = '0;
        point.valid = 1'b0;
        point.x_coord = '0;
        point.y_coord = '0;
        point.w_coord = '0;
        coef = '{32'sh0010_0000, 0, 0, 0, 32'sh0010_0000, 0, 0, 0, 32'sh0100_0000};

        // directed points under the reset identity matrix
        dir_tab[0]  = '{0, 0, 256, 1'b1, '{0, 0, 1, 0}};
        dir_tab[1]  = '{1280, -768, 256, 1'b1, '{1280, -768, 1, 0}};
        dir_tab[2]  = '{8388607, -8388608, 256, 1'b1, '{8388607, -8388608, 1, 0}};
        dir_tab[3]  = '{-8388608, 8388607, 256, 1'b1, '{-8388608, 8388607, 1, 0}};
        dir_tab[4]  = '{0, 0, 0, 1'b1, '{-256, -256, 0, 0}};
        dir_tab[5]  = '{8388607, -8388608, 0, 1'b1, '{-256, -256, 0, 0}};
        dir_tab[6]  = '{512, -512, -256, 1'b1, '{-512, 512, 1, 0}};
        dir_tab[7]  = '{-8388608, 0, -256, 1'b1, '{8388607, 0, 1, 1}};
        dir_tab[8]  = '{256, 256, 128, 1'b0, none};
        dir_tab[9]  = '{8388607, 1000, 1, 1'b0, none};
        dir_tab[10] = '{-12345, 54321, 32767, 1'b0, none};
        dir_tab[11] = '{777, -8388608, -32768, 1'b0, none};

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (i = 0; i < 12; i++)
            send_point(dir_tab[i].x, dir_tab[i].y, dir_tab[i].w,
                       dir_tab[i].typed, dir_tab[i].res);
        drain();

        // random phases, each with its own matrix
        for (ph = 0; ph < 8; ph++)
        begin
            kind = (ph < 2) ? ph : ((ph == 4) ? 2 : 3);
            load_matrix(kind);
            quiet = (ph == 3);
            for (i = 0; i < 250; i++)
            begin
                if (ph == 5 && i == 20)
                    hold_req = 1'b1;
                wide = (kind < 3) || ($urandom_range(0, 9) == 0);
                case ($urandom_range(0, 9))
                    0:       w = 16'($urandom);
                    1:       w = 16'sd0;
                    2:       w = -16'sd256;
                    default: w = 16'sd256;
                endcase
                send_point(rand_coord(wide), rand_coord(wide), w, 1'b0, none);
            end
            drain();
        end

        quiet = 1'b0;
        repeat (40) @(posedge clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

[homography_point_projection.f]
rtl/hpp_pkg.sv
rtl/hpp_point_if.sv
rtl/hpp_proj_if.sv
rtl/hpp_front.sv
rtl/hpp_div_step.sv
rtl/hpp_back.sv
rtl/homography_point_projection.sv
rtl/hpp_check.sv
tb/sv/homography_point_projection_tb.sv
